@@ src/rolling_hash_substring_matcher_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Rolling hash matcher: assertion macros
// Shared concurrent assertion forms for the matcher's RTL.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_UNIT_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/rhsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Rolling hash matcher package
// Hash base, item kind codes and types shared by the matcher's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsm_pkg;

   typedef logic [63:0] hash_type;

   localparam hash_type HashBase = 64'd100071;

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_TEXT    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   // Control for one step of the window hash unit.
   typedef struct packed {
      logic step;
      logic text;
      logic restart;
   } roll_ctl_type;

endpackage

`default_nettype wire

@@ src/rhsm_channels.sv @@
// ----------------------------------------------------------------------------
// Rolling hash matcher channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface rhsm_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic pattern_overflow;

   modport source (output valid, output match, output pattern_overflow, input ready);
   modport sink (input valid, input match, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ src/rhsm_roll.sv @@
// ----------------------------------------------------------------------------
// Rolling hash matcher: window hash unit
// Holds the rolling window hash and fill count, advances them one word
// per step and clears them on a restart step.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsm_roll #(
   parameter int LEN_W = 13
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire rhsm_pkg::roll_ctl_type ctl,
   input  wire [7:0]                   byte_value,
   input  wire [LEN_W-1:0]             plen,
   input  wire rhsm_pkg::hash_type     prod,
   output rhsm_pkg::hash_type          window_hash,
   output logic                        cand
);

   rhsm_pkg::hash_type hash_ff, hash_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   rhsm_pkg::hash_type shifted;
   logic [LEN_W-1:0]   fill_next;

   assign shifted   = hash_ff * rhsm_pkg::HashBase + 64'(byte_value);
   assign fill_next = fill_ff + LEN_W'(1);

   always_comb begin
      hash_in = hash_ff;
      fill_in = fill_ff;
      cand    = 1'b0;
      if (ctl.step) begin
         if (ctl.restart) begin
            hash_in = '0;
            fill_in = '0;
         end else if (ctl.text && plen != '0) begin
            if (fill_ff < plen) begin
               hash_in = shifted;
               fill_in = fill_next;
               cand    = (fill_next == plen);
            end else begin
               // Full window: the oldest word drops out, weighted by base^len.
               hash_in = shifted - prod;
               cand    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         fill_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         fill_ff <= fill_in;
      end
   end

   assign window_hash = hash_ff;

endmodule

`default_nettype wire

@@ src/rolling_hash_substring_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Rolling hash substring matcher
// Streaming Rabin-Karp matcher with a 64-bit polynomial hash, base 100071.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                          Handshake
//  req_chan  in   kind[1:0], byte_value[7:0]       valid/ready
//  rsp_chan  out  match, pattern_overflow          valid/ready
//
//  One word per cycle sustained while responses are taken; the response is
//  registered. The rate is set by the window hash recurrence in rhsm_roll,
//  one multiply-add per word, and by the read of the history memory.
//  Reset is synchronous and clears the hashes, lengths and pointers; the
//  history memory is not cleared and needs no pass after reset.
//  Each stage moves when the stage after it is empty or draining, so a
//  stalled response only stops the pipeline once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rolling_hash_substring_matcher_unit_defines.svh"

module rolling_hash_substring_matcher_unit #(
   parameter int MAX_PATTERN = 4096
) (
   input wire          clock,
   input wire          reset,
   rhsm_req_if.sink    req_chan,
   rhsm_rsp_if.source  rsp_chan
);

   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam logic [LEN_W-1:0]  MaxLen   = LEN_W'(MAX_PATTERN);
   localparam logic [LEN_W:0]    MaxExt   = (LEN_W + 1)'(MAX_PATTERN);
   localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(MAX_PATTERN - 1);

   typedef struct packed {
      logic               text;
      logic               restart;
      logic               over;
      logic [7:0]         c;
      logic [LEN_W-1:0]   plen;
      rhsm_pkg::hash_type phash;
      rhsm_pkg::hash_type bp;
   } st1_type;

   typedef struct packed {
      logic               text;
      logic               restart;
      logic               over;
      logic [7:0]         c;
      logic [LEN_W-1:0]   plen;
      rhsm_pkg::hash_type phash;
      rhsm_pkg::hash_type prod;
   } st2_type;

   // Pattern state and history pointer, updated as words are accepted.
   rhsm_pkg::hash_type phash_ff, phash_in;
   rhsm_pkg::hash_type bp_ff, bp_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic [7:0] hist_mem [MAX_PATTERN];
   logic [7:0] rd_ff;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   st1_type            st1_ff, st1_in;
   st2_type            st2_ff;
   logic               s3_cand_ff, s3_over_ff;
   rhsm_pkg::hash_type s3_phash_ff;

   logic accept, hist_we;
   logic s1_ready, s2_ready, s3_ready;
   logic [LEN_W:0]     back_sum, back_wrap;
   logic [SLOT_W-1:0]  back_slot;

   rhsm_pkg::roll_ctl_type roll_ctl;
   rhsm_pkg::hash_type     win_hash;
   logic                   roll_cand;

   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_chan.ready = s1_ready;
   assign accept         = req_chan.valid && s1_ready;
   assign hist_we        = accept && (req_chan.kind == rhsm_pkg::KIND_TEXT);

   // Slot of the word leaving the window: write slot minus pattern length, wrapped.
   assign back_sum  = (LEN_W + 1)'(slot_ff) + MaxExt - (LEN_W + 1)'(plen_ff);
   assign back_wrap = (back_sum >= MaxExt) ? (back_sum - MaxExt) : back_sum;
   assign back_slot = back_wrap[SLOT_W-1:0];

   always_comb begin
      phash_in       = phash_ff;
      bp_in          = bp_ff;
      plen_in        = plen_ff;
      slot_in        = slot_ff;
      st1_in.text    = 1'b0;
      st1_in.restart = 1'b0;
      st1_in.over    = 1'b0;
      st1_in.c       = req_chan.byte_value;
      if (accept) begin
         case (req_chan.kind)
            rhsm_pkg::KIND_PATTERN: begin
               if (plen_ff < MaxLen) begin
                  phash_in       = phash_ff * rhsm_pkg::HashBase
                                   + 64'(req_chan.byte_value);
                  bp_in          = bp_ff * rhsm_pkg::HashBase;
                  plen_in        = plen_ff + LEN_W'(1);
                  st1_in.restart = 1'b1;
               end else begin
                  st1_in.over = 1'b1;
               end
            end
            rhsm_pkg::KIND_TEXT: begin
               st1_in.text = 1'b1;
               slot_in     = (slot_ff == SlotLast) ? '0 : slot_ff + SLOT_W'(1);
            end
            rhsm_pkg::KIND_CLEAR: begin
               phash_in       = '0;
               bp_in          = 64'd1;
               plen_in        = '0;
               slot_in        = '0;
               st1_in.restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
      st1_in.plen  = plen_in;
      st1_in.phash = phash_in;
      st1_in.bp    = bp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phash_ff <= '0;
         bp_ff    <= 64'd1;
         plen_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         phash_ff <= phash_in;
         bp_ff    <= bp_in;
         plen_ff  <= plen_in;
         slot_ff  <= slot_in;
      end
   end

   // The read returns the old word when the leaving slot is the one being written.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[slot_ff] <= req_chan.byte_value;
      end
      if (accept) begin
         rd_ff <= hist_mem[back_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= accept;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         st1_ff <= st1_in;
      end
      if (s2_ready) begin
         st2_ff.text    <= st1_ff.text;
         st2_ff.restart <= st1_ff.restart;
         st2_ff.over    <= st1_ff.over;
         st2_ff.c       <= st1_ff.c;
         st2_ff.plen    <= st1_ff.plen;
         st2_ff.phash   <= st1_ff.phash;
         st2_ff.prod    <= 64'(rd_ff) * st1_ff.bp;
      end
      if (s3_ready) begin
         s3_cand_ff  <= roll_cand;
         s3_over_ff  <= st2_ff.over;
         s3_phash_ff <= st2_ff.phash;
      end
   end

   assign roll_ctl.step    = s2_valid_ff && s3_ready;
   assign roll_ctl.text    = st2_ff.text;
   assign roll_ctl.restart = st2_ff.restart;

   rhsm_roll #(
      .LEN_W (LEN_W)
   ) u_roll (
      .clock       (clock),
      .reset       (reset),
      .ctl         (roll_ctl),
      .byte_value  (st2_ff.c),
      .plen        (st2_ff.plen),
      .prod        (st2_ff.prod),
      .window_hash (win_hash),
      .cand        (roll_cand)
   );

   // The window hash only moves when a word enters the output stage, so it
   // stays paired with the held response.
   assign rsp_chan.valid            = s3_valid_ff;
   assign rsp_chan.match            = s3_cand_ff && (win_hash == s3_phash_ff);
   assign rsp_chan.pattern_overflow = s3_over_ff;

   `RHSM_ASSERT_SAME(a_slot_range, clock, reset, 1'b1, slot_ff <= SlotLast, "write slot out of range")
   `RHSM_ASSERT_SAME(a_plen_range, clock, reset, 1'b1, plen_ff <= MaxLen, "pattern length beyond maximum")
   `RHSM_ASSERT_SAME(a_rsp_excl, clock, reset, rsp_chan.valid, !(rsp_chan.match && rsp_chan.pattern_overflow), "match and overflow together")
   `RHSM_ASSERT_NEXT(a_clear, clock, reset, accept && (req_chan.kind == rhsm_pkg::KIND_CLEAR), (plen_ff == '0) && (slot_ff == '0) && (bp_ff == 64'd1), "clear left state behind")

endmodule

`default_nettype wire
